@@ hdl/lrss_pkg.sv @@
// Shared constants for the Life row stencil block.
// No dependencies; every module of the block imports this package.
package lrss_pkg;

  // Cells in one row, as carried on the stream.
  localparam int unsigned RowBits = 64;

  // Width of the row width register.
  localparam int unsigned CfgBits = 7;

  // Row width after reset: the full row.
  localparam logic [CfgBits-1:0] RowWidthReset = 7'd64;

  // Neighbor counts that matter for the B3/S23 rule.
  localparam logic [3:0] CountSurvive = 4'd2;
  localparam logic [3:0] CountBirth   = 4'd3;

  typedef logic [RowBits-1:0] row_t;

endpackage

@@ hdl/life_row_stencil_step.sv @@
// Life row stencil step: one row request in, next state of the row above it out.
// A request passes through the input register and then the result register.
// Throughput: one row per cycle while the result side is ready; a bottom row that also
// flushes a held row gives its two results in turn, since both share the single rule unit.
// Reset clears held rows and valid flags and sets the row width to 64.
module life_row_stencil_step #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Row width register write.
  input  logic                     cfg_we_i,
  input  logic [6:0]               cfg_wdata_i,
  // Input row requests.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [127:0]             s_axis_tdata,  // [63:0] row_cells, [127:64] birth_mask
  input  logic                     s_axis_tlast,  // last_row
  // Result rows.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [63:0]              m_axis_tdata,  // [63:0] next_row
  output logic                     m_axis_tlast   // frame_last
);
  import lrss_pkg::*;

  localparam logic [CfgBits-1:0] MaxW = CfgBits'(MAX_WIDTH);

  logic [CfgBits-1:0] width_q;
  logic [CfgBits-1:0] width_eff;
  row_t               wmask;

  logic s1_valid_q, s1_last_q, s1_half_q;
  row_t s1_row_q, s1_births_q, row_m;

  row_t upper_q, middle_q, mmask_q;
  logic mvalid_q;

  logic out_valid_q, out_last_q;
  row_t out_row_q;

  logic emit, split, res_last, out_free, go, done, accept;
  row_t gen_up, gen_mid, gen_low, gen_births, gen_next;

  // Row width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RowWidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Mask of cells in use, clamped to the configured maximum.
  assign width_eff = (width_q > MaxW) ? MaxW : width_q;
  always_comb begin
    for (int x = 0; x < RowBits; x++) begin
      wmask[x] = (CfgBits'(x) < width_eff);
    end
  end

  assign row_m = s1_row_q & wmask;

  // Pick the rows for the rule unit. The second half of a split request
  // flushes the held middle row with a dead row below it.
  always_comb begin
    emit       = 1'b0;
    split      = 1'b0;
    res_last   = 1'b0;
    gen_up     = upper_q;
    gen_mid    = middle_q;
    gen_low    = '0;
    gen_births = mmask_q;
    if (s1_half_q) begin
      emit     = 1'b1;
      res_last = 1'b1;
    end else if (mvalid_q) begin
      emit    = 1'b1;
      split   = s1_last_q;
      gen_low = row_m;
    end else begin
      emit       = s1_last_q;
      res_last   = 1'b1;
      gen_up     = '0;
      gen_mid    = row_m;
      gen_births = s1_births_q;
    end
  end

  lrss_next_gen u_next_gen (
    .up_i     (gen_up),
    .mid_i    (gen_mid),
    .low_i    (gen_low),
    .births_i (gen_births),
    .wmask_i  (wmask),
    .next_o   (gen_next)
  );

  // Handshake: the held request moves when its result has a free slot, or at once if it makes no result.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign go            = s1_valid_q && (!emit || out_free);
  assign done          = go && !split;
  assign s_axis_tready = !s1_valid_q || done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_half_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (done) begin
        s1_valid_q <= 1'b0;
      end
      if (go && split) begin
        s1_half_q <= 1'b1;
      end else if (done) begin
        s1_half_q <= 1'b0;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q    <= s_axis_tdata[RowBits-1:0];
      s1_births_q <= s_axis_tdata[2*RowBits-1:RowBits];
      s1_last_q   <= s_axis_tlast;
    end
  end

  // Held rows: shift the window down, or clear it at the end of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      mmask_q  <= '0;
      mvalid_q <= 1'b0;
    end else if (go) begin
      if (s1_half_q || (s1_last_q && !mvalid_q)) begin
        upper_q  <= '0;
        middle_q <= '0;
        mmask_q  <= '0;
        mvalid_q <= 1'b0;
      end else begin
        upper_q  <= mvalid_q ? middle_q : '0;
        middle_q <= row_m;
        mmask_q  <= s1_births_q;
        mvalid_q <= 1'b1;
      end
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_row_q  <= gen_next;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_row_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hdl/lrss_next_gen.sv @@
// Next-generation logic for one row of a Life grid (B3/S23, plus births from a mask).
// Depends on lrss_pkg for the row type and rule constants.
module lrss_next_gen (
  input  lrss_pkg::row_t up_i,
  input  lrss_pkg::row_t mid_i,
  input  lrss_pkg::row_t low_i,
  input  lrss_pkg::row_t births_i,
  input  lrss_pkg::row_t wmask_i,
  output lrss_pkg::row_t next_o
);
  import lrss_pkg::*;

  logic [RowBits+1:0] up_pad;
  logic [RowBits+1:0] mid_pad;
  logic [RowBits+1:0] low_pad;
  row_t               next_raw;

  // Mask rows to the width in use and pad with dead cells at both edges.
  assign up_pad  = {1'b0, up_i & wmask_i, 1'b0};
  assign mid_pad = {1'b0, mid_i & wmask_i, 1'b0};
  assign low_pad = {1'b0, low_i & wmask_i, 1'b0};

  // Each cell counts its eight neighbors independently of the others.
  for (genvar x = 0; x < RowBits; x++) begin : g_cell
    logic [3:0] count;
    logic       alive;

    assign count = 4'(up_pad[x]) + 4'(up_pad[x+1]) + 4'(up_pad[x+2])
                 + 4'(mid_pad[x]) + 4'(mid_pad[x+2])
                 + 4'(low_pad[x]) + 4'(low_pad[x+1]) + 4'(low_pad[x+2]);
    assign alive = mid_pad[x+1];

    // A dead cell without a regular birth may still get a miracle birth.
    assign next_raw[x] = alive ? (count == CountSurvive || count == CountBirth)
                               : (count == CountBirth || births_i[x]);
  end

  // Cells beyond the width stay dead even where a birth is requested.
  assign next_o = next_raw & wmask_i;

endmodule
